[design/iir_biquad_direct_form_one_defines.svh]
// assertion macros for the biquad filter
// included by the top level, no other dependencies
`ifndef IIR_BIQUAD_DIRECT_FORM_ONE_DEFINES_SVH
`define IIR_BIQUAD_DIRECT_FORM_ONE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/iir_pkg.sv]
// types and constants for the biquad filter
// no dependencies
package iir_pkg;

    // field and datapath widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned SCALED_W   = 10;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned A0_W       = 15;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned ACC_W      = 40;
    localparam int unsigned REM_W      = A0_W + 1;
    localparam int unsigned RADIX_BITS = 4;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned CFG_ADDR_W = 3;

    // sequencer step limits
    localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(5);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(ACC_W / RADIX_BITS);

    // rounding bias that makes the arithmetic shift truncate toward zero
    localparam logic [SAMPLE_W-1:0] SCALE_BIAS = SAMPLE_W'(63);

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_A0 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_A1 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_A2 = 3'd5;

    // coefficient values after reset
    localparam logic signed [COEF_W-1:0] B0_RST = 16'sd49;
    localparam logic signed [COEF_W-1:0] B1_RST = 16'sd79;
    localparam logic signed [COEF_W-1:0] B2_RST = 16'sd49;
    localparam logic        [A0_W-1:0]   A0_RST = 15'd100;
    localparam logic signed [COEF_W-1:0] A1_RST = 16'sd50;
    localparam logic signed [COEF_W-1:0] A2_RST = 16'sd40;

    // saturation limits
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_FIN
    } t_state;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic ready;
        logic mac_en;
        logic div_en;
        logic load_out;
    } t_ctrl;

endpackage

[design/iir_biquad_direct_form_one.sv]
// second-order iir filter, direct form one, one shared multiplier and divider
// depends on iir_pkg and iir_biquad_direct_form_one_defines.svh
`include "iir_biquad_direct_form_one_defines.svh"

// Usage
// Input words arrive on the s_axis channel, one signed 16-bit sample each.
// Results leave on the m_axis channel, one signed 16-bit sample per input.
// Coefficients are written through the cfg port (b0, b1, b2, a0, a1, a2 at
// indexes 0..5) while no sample is in flight; a write lands at the clock edge.
// Each sample is scaled by 1/64, run through five multiply-accumulate steps on
// one 16x16 multiplier, then divided by a0 with a radix-16 restoring divider
// that retires four quotient bits a cycle over the 40-bit sum.
// When a0 is zero the divider is skipped and the result saturates by the sign
// of the sum. The block takes no new sample until it is through with the last;
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next sample is taken as soon
// as the result is parked there; a stalled receiver holds the block in its
// final step until the waiting word is taken.
// Reset clears both history lines, restores the default coefficients and
// leaves the output channel empty.
module iir_biquad_direct_form_one (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side: tdata = sample_in [15:0]
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [iir_pkg::SAMPLE_W-1:0]     i_s_axis_tdata,
    // master side: tdata = sample_out [15:0]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [iir_pkg::SAMPLE_W-1:0]     o_m_axis_tdata,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [iir_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [iir_pkg::COEF_W-1:0]       i_cfg_wr_data
);
    import iir_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [STEP_W-1:0] r_step;

    // coefficients
    logic signed [COEF_W-1:0] r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic        [A0_W-1:0]   r_coef_a0;

    // history lines, newest first
    logic signed [SCALED_W-1:0] r_xs, r_x1, r_x2;
    logic signed [SAMPLE_W-1:0] r_y1, r_y2;

    // datapath registers
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_sub;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [ACC_W-1:0]         r_dvd, n_dvd;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic signed [SAMPLE_W-1:0] scale_sum;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic [ACC_W-1:0]           acc_mag;
    logic signed [SAMPLE_W-1:0] result;
    logic                       a0_zero;

    assign a0_zero = (r_coef_a0 == '0);

    // divide by 64 truncating toward zero: bias negatives then shift
    assign scale_sum = i_s_axis_tdata[SAMPLE_W-1]
                     ? $signed(i_s_axis_tdata + SCALE_BIAS)
                     : $signed(i_s_axis_tdata);
    assign scaled = scale_sum[SAMPLE_W-1:SAMPLE_W-SCALED_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_s_axis_tvalid) n_state = ST_MAC;
            ST_MAC:  if (r_step == MAC_LAST) n_state = ST_DIV;
            ST_DIV: begin
                if ((r_step == '0 && a0_zero) || r_step == DIV_LAST) n_state = ST_FIN;
            end
            ST_FIN:  if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: ctrl.ready = 1'b1;
            ST_MAC:  ctrl.mac_en = 1'b1;
            ST_DIV:  ctrl.div_en = 1'b1;
            ST_FIN:  ctrl.load_out = !r_out_valid || i_m_axis_tready;
            default: ctrl = '0;
        endcase
    end

    assign o_s_axis_tready = ctrl.ready;

    // operand select for the shared multiplier
    always_comb begin
        case (r_step)
            4'd0:    begin mul_a = r_coef_b0; mul_b = SAMPLE_W'(r_xs); end
            4'd1:    begin mul_a = r_coef_b1; mul_b = SAMPLE_W'(r_x1); end
            4'd2:    begin mul_a = r_coef_b2; mul_b = SAMPLE_W'(r_x2); end
            4'd3:    begin mul_a = r_coef_a1; mul_b = r_y1; end
            4'd4:    begin mul_a = r_coef_a2; mul_b = r_y2; end
            default: begin mul_a = '0;        mul_b = '0; end
        endcase
    end

    assign prod_ext = ACC_W'(r_prod);
    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // four restoring division steps per cycle
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [ACC_W-1:0] dvd;
        rem = r_rem;
        dvd = r_dvd;
        for (int i = 0; i < RADIX_BITS; i++) begin
            rem = {rem[REM_W-2:0], dvd[ACC_W-1]};
            dvd = {dvd[ACC_W-2:0], 1'b0};
            if (rem >= REM_W'(r_coef_a0)) begin
                rem    = rem - REM_W'(r_coef_a0);
                dvd[0] = 1'b1;
            end
        end
        n_rem = rem;
        n_dvd = dvd;
    end

    // saturate the signed quotient, or the sign alone when a0 is zero
    always_comb begin
        if (a0_zero) begin
            result = r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end else if (r_acc[ACC_W-1]) begin
            result = (r_dvd > ACC_W'(32768)) ? SAT_MIN : $signed(-r_dvd[SAMPLE_W-1:0]);
        end else begin
            result = (r_dvd > ACC_W'(32767)) ? SAT_MAX : $signed(r_dvd[SAMPLE_W-1:0]);
        end
    end

    // control, coefficients and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_coef_b0   <= B0_RST;
            r_coef_b1   <= B1_RST;
            r_coef_b2   <= B2_RST;
            r_coef_a0   <= A0_RST;
            r_coef_a1   <= A1_RST;
            r_coef_a2   <= A2_RST;
            r_xs        <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? '0 : r_step + STEP_W'(1);

            // coefficient writes
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_B0:  r_coef_b0 <= i_cfg_wr_data;
                    CFG_B1:  r_coef_b1 <= i_cfg_wr_data;
                    CFG_B2:  r_coef_b2 <= i_cfg_wr_data;
                    CFG_A0:  r_coef_a0 <= i_cfg_wr_data[A0_W-1:0];
                    CFG_A1:  r_coef_a1 <= i_cfg_wr_data;
                    CFG_A2:  r_coef_a2 <= i_cfg_wr_data;
                    default: ;
                endcase
            end

            // take a new sample
            if (ctrl.ready && i_s_axis_tvalid) r_xs <= scaled;

            // result goes out, histories shift
            if (ctrl.load_out) begin
                r_out_valid <= 1'b1;
                r_x1        <= r_xs;
                r_x2        <= r_x1;
                r_y1        <= result;
                r_y2        <= r_y1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (ctrl.ready) begin
            r_acc <= '0;
        end
        if (ctrl.mac_en) begin
            r_prod     <= mul_a * mul_b;
            r_prod_sub <= (r_step >= STEP_W'(3));
            if (r_step != '0) begin
                r_acc <= r_prod_sub ? r_acc - prod_ext : r_acc + prod_ext;
            end
        end
        if (ctrl.div_en) begin
            if (r_step == '0) begin
                r_rem <= '0;
                r_dvd <= acc_mag;
            end else begin
                r_rem <= n_rem;
                r_dvd <= n_dvd;
            end
        end
        if (ctrl.load_out) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `IIR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready after accept")
    `IIR_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n,
        r_state == ST_DIV && r_step != '0 && !a0_zero, r_rem < REM_W'(r_coef_a0),
        "remainder not below divisor")
    `IIR_ASSERT_NOW(a_valid_from_final, i_clk, i_rst_n,
        $rose(o_m_axis_tvalid), $past(r_state == ST_FIN), "result without final step")

endmodule
